// File: rtl/ppm_p6_stream_parser_assert.svh
// Assertion macros used by the pixmap stream parser module.
`ifndef PPM_P6_STREAM_PARSER_ASSERT_SVH
`define PPM_P6_STREAM_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppm_p6 parser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppm_p6 parser: next-cycle check failed");

`endif

// File: rtl/ppm_p6_pkg.sv
package ppm_p6_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned HDR_CNT_W = $clog2(HEADER_BYTES + 1);

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_6 = 8'h36;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [15:0] VAL_MAX = 16'hFFFF;

  localparam int unsigned TDATA_W = 112;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_REPORT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_MAGIC  = 2'd1,
    ST_BAD_LENGTH = 2'd2,
    ST_TRUNCATED  = 2'd3
  } status_e;

  typedef struct packed {
    logic        active;
    logic        bad;
    logic        done;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] depth;
  } hdr_res_t;

  function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [3:0] d);
    logic [19:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, d};
    return (v > {4'b0, VAL_MAX}) ? VAL_MAX : v[15:0];
  endfunction

endpackage

// File: rtl/ppm_p6_hdr.sv
module ppm_p6_hdr (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 clear_i,
  input  logic [7:0]           byte_i,
  output ppm_p6_pkg::hdr_res_t res_o
);
  import ppm_p6_pkg::*;

  logic [HDR_CNT_W-1:0] count_q, count_d;
  logic [1:0]  line_q, line_d;
  logic [1:0]  magic_cnt_q, magic_cnt_d;
  logic        magic_ok_q, magic_ok_d;
  logic        second_q, second_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [15:0] depth_q, depth_d;
  logic        is_digit;
  logic [3:0]  digit;
  logic [7:0]  digit_full;
  logic        bad;

  assign is_digit = byte_i inside {[CHAR_0:CHAR_9]};
  assign digit_full = byte_i - CHAR_0;
  assign digit = digit_full[3:0];

  always_comb begin
    count_d = count_q;
    line_d = line_q;
    magic_cnt_d = magic_cnt_q;
    magic_ok_d = magic_ok_q;
    second_d = second_q;
    width_d = width_q;
    height_d = height_q;
    depth_d = depth_q;
    bad = 1'b0;
    if (step_i) begin
      count_d = count_q + 1'b1;
      if (byte_i == CHAR_NL) begin
        bad = (line_q == 2'd0) && !(magic_ok_q && magic_cnt_q == 2'd2);
        if (line_q != 2'd3) begin
          line_d = line_q + 2'd1;
        end
      end else if (line_q == 2'd0) begin
        case (magic_cnt_q)
          2'd0: begin
            if (byte_i != CHAR_P) magic_ok_d = 1'b0;
          end
          2'd1: begin
            if (byte_i != CHAR_6) magic_ok_d = 1'b0;
          end
          default: begin
            magic_ok_d = 1'b0;
          end
        endcase
        if (magic_cnt_q != 2'd3) begin
          magic_cnt_d = magic_cnt_q + 2'd1;
        end
      end else if (line_q == 2'd1) begin
        if (byte_i == CHAR_SP) begin
          second_d = 1'b1;
        end else if (is_digit) begin
          if (second_q) begin
            height_d = add_digit(height_q, digit);
          end else begin
            width_d = add_digit(width_q, digit);
          end
        end
      end else if (line_q == 2'd2) begin
        if (is_digit) begin
          depth_d = add_digit(depth_q, digit);
        end
      end
    end
  end

  always_comb begin
    res_o.active = count_q < HDR_CNT_W'(HEADER_BYTES);
    res_o.bad = bad;
    res_o.done = step_i && (count_q == HDR_CNT_W'(HEADER_BYTES - 1));
    res_o.width = width_d;
    res_o.height = height_d;
    res_o.depth = depth_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      line_q <= '0;
      magic_cnt_q <= '0;
      magic_ok_q <= 1'b1;
      second_q <= 1'b0;
      width_q <= '0;
      height_q <= '0;
      depth_q <= '0;
    end else if (clear_i) begin
      count_q <= '0;
      line_q <= '0;
      magic_cnt_q <= '0;
      magic_ok_q <= 1'b1;
      second_q <= 1'b0;
      width_q <= '0;
      height_q <= '0;
      depth_q <= '0;
    end else begin
      count_q <= count_d;
      line_q <= line_d;
      magic_cnt_q <= magic_cnt_d;
      magic_ok_q <= magic_ok_d;
      second_q <= second_d;
      width_q <= width_d;
      height_q <= height_d;
      depth_q <= depth_d;
    end
  end

endmodule

// File: rtl/ppm_p6_stream_parser.sv
// Binary P6 pixmap parser. One file byte is taken per request, one per clock cycle unless the
// output is stalled, and each byte yields at most one result in the next cycle through a single
// output register. The first 16 bytes are the header: a header-complete result carries the parsed
// width, height and color depth, every third body byte yields a pixel with its column and row, and
// a bad magic line, a truncated header or leftover body bytes are reported with a status. The byte
// marked tlast closes the file, and the parser is then ready for the next file.
module ppm_p6_stream_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // data_byte
  input  logic                                s_axis_tlast,  // last_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status, pixel_x, pixel_y, red, green, blue, image_width, image_height, color_depth,
  // zero fill
  output logic [ppm_p6_pkg::TDATA_W-1:0]      m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,  // kind
  output logic                                m_axis_tlast   // final_res
);
  `include "ppm_p6_stream_parser_assert.svh"
  import ppm_p6_pkg::*;

  hdr_res_t    hdr_res;
  logic        accept;
  logic        hdr_step;
  logic        body_step;
  logic        clear;

  logic        failed_q;
  logic [1:0]  phase_q;
  logic [7:0]  red_q;
  logic [7:0]  green_q;
  logic [15:0] column_q;
  logic [15:0] row_q;
  logic [16:0] column_inc;

  logic        res_valid;
  kind_e       res_kind;
  status_e     res_status;
  logic        res_fin;
  logic [15:0] res_x;
  logic [15:0] res_y;
  logic [7:0]  res_r;
  logic [7:0]  res_g;
  logic [7:0]  res_b;

  logic        m_valid_q;
  kind_e       kind_q;
  status_e     status_q;
  logic        fin_q;
  logic [15:0] x_q;
  logic [15:0] y_q;
  logic [7:0]  r_q;
  logic [7:0]  g_q;
  logic [7:0]  b_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic [15:0] depth_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign clear = accept && s_axis_tlast;
  assign hdr_step = accept && !failed_q && hdr_res.active;
  assign body_step = accept && !failed_q && !hdr_res.active;
  assign column_inc = {1'b0, column_q} + 17'd1;

  ppm_p6_hdr u_hdr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (hdr_step),
    .clear_i(clear),
    .byte_i (s_axis_tdata),
    .res_o  (hdr_res)
  );

  always_comb begin
    res_valid = 1'b0;
    res_kind = KIND_REPORT;
    res_status = ST_OK;
    res_fin = s_axis_tlast;
    res_x = '0;
    res_y = '0;
    res_r = '0;
    res_g = '0;
    res_b = '0;
    if (failed_q) begin
      res_valid = s_axis_tlast;
      res_status = ST_BAD_MAGIC;
    end else if (hdr_res.active) begin
      if (hdr_res.bad) begin
        res_valid = 1'b1;
        res_status = ST_BAD_MAGIC;
      end else if (hdr_res.done) begin
        res_valid = 1'b1;
        res_kind = KIND_HEADER;
      end else begin
        res_valid = s_axis_tlast;
        res_status = ST_TRUNCATED;
      end
    end else if (phase_q == 2'd2) begin
      res_valid = 1'b1;
      res_kind = KIND_PIXEL;
      res_x = column_q;
      res_y = row_q;
      res_r = red_q;
      res_g = green_q;
      res_b = s_axis_tdata;
    end else begin
      res_valid = s_axis_tlast;
      res_status = ST_BAD_LENGTH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failed_q <= 1'b0;
      phase_q <= '0;
      red_q <= '0;
      green_q <= '0;
      column_q <= '0;
      row_q <= '0;
    end else if (clear) begin
      failed_q <= 1'b0;
      phase_q <= '0;
      red_q <= '0;
      green_q <= '0;
      column_q <= '0;
      row_q <= '0;
    end else begin
      if (hdr_step && hdr_res.bad) begin
        failed_q <= 1'b1;
      end
      if (body_step) begin
        case (phase_q)
          2'd0: begin
            red_q <= s_axis_tdata;
            phase_q <= 2'd1;
          end
          2'd1: begin
            green_q <= s_axis_tdata;
            phase_q <= 2'd2;
          end
          default: begin
            phase_q <= 2'd0;
            if (column_inc >= {1'b0, hdr_res.width}) begin
              column_q <= '0;
              row_q <= row_q + 16'd1;
            end else begin
              column_q <= column_inc[15:0];
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept && res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      kind_q <= res_kind;
      status_q <= res_status;
      fin_q <= res_fin;
      x_q <= res_x;
      y_q <= res_y;
      r_q <= res_r;
      g_q <= res_g;
      b_q <= res_b;
      width_q <= hdr_res.width;
      height_q <= hdr_res.height;
      depth_q <= hdr_res.depth;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser = kind_q;
  assign m_axis_tlast = fin_q;
  assign m_axis_tdata = {6'b0, depth_q, height_q, width_q, b_q, g_q, r_q, y_q, x_q, status_q};

  `PPM_ASSERT_NOW(a_phase_range, 1'b1, phase_q != 2'd3)
  `PPM_ASSERT_NOW(a_failed_no_body, failed_q, phase_q == 2'd0)
  `PPM_ASSERT_NEXT(a_last_clears, clear, !failed_q && phase_q == 2'd0 && column_q == 16'd0)
  `PPM_ASSERT_NEXT(a_pixel_out, body_step && phase_q == 2'd2,
                   m_valid_q && kind_q == KIND_PIXEL && status_q == ST_OK)
  `PPM_ASSERT_NOW(a_stall_blocks, m_valid_q && !m_axis_tready, !s_axis_tready)

endmodule

// File: verif/ppm_p6_stream_parser_test.sv
module ppm_p6_stream_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ppm_p6_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef struct {
    kind_e       kind;
    logic        fin;
    status_e     status;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] d;
  } pixmap_res_t;

  typedef logic [7:0] file_bytes_t[$];

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  byte_req_t   byte_q[$];
  pixmap_res_t pixel_exp_q[$];
  int          err_cnt = 0;
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        in_fire = 1'b0;
  logic        hold_long = 1'b0;

  // Parser state tracked alongside the block.
  int unsigned hdr_cnt;
  int unsigned line_idx;
  int unsigned magic_n;
  bit          magic_good;
  bit          on_height;
  int unsigned wid;
  int unsigned hgt;
  int unsigned dep;
  int unsigned col;
  int unsigned row;
  int unsigned phase;
  logic [7:0]  hold_r;
  logic [7:0]  hold_g;
  bit          in_error;

  ppm_p6_stream_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  task automatic clear_parser();
    hdr_cnt = 0;
    line_idx = 0;
    magic_n = 0;
    magic_good = 1;
    on_height = 0;
    wid = 0;
    hgt = 0;
    dep = 0;
    col = 0;
    row = 0;
    phase = 0;
    hold_r = '0;
    hold_g = '0;
    in_error = 0;
  endtask

  function automatic int unsigned dec_push(int unsigned acc, int unsigned dig);
    int unsigned v;
    v = acc * 10 + dig;
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic pixmap_res_t make_res(kind_e k, logic fin, status_e st,
                                           int unsigned x = 0, int unsigned y = 0,
                                           logic [7:0] r = 0, logic [7:0] g = 0,
                                           logic [7:0] b = 0);
    pixmap_res_t res;
    res.kind = k;
    res.fin = fin;
    res.status = st;
    res.x = x[15:0];
    res.y = y[15:0];
    res.r = r;
    res.g = g;
    res.b = b;
    res.w = wid[15:0];
    res.h = hgt[15:0];
    res.d = dep[15:0];
    return res;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic last, output bit has_res,
                              output pixmap_res_t res);
    bit bad;
    bit is_digit;
    has_res = 0;
    res = make_res(KIND_PIXEL, 1'b0, ST_OK);
    if (in_error) begin
      if (last) begin
        has_res = 1;
        res = make_res(KIND_REPORT, 1'b1, ST_BAD_MAGIC);
        clear_parser();
      end
      return;
    end
    if (hdr_cnt < HEADER_BYTES) begin
      bad = 0;
      is_digit = (b >= CHAR_0) && (b <= CHAR_9);
      if (b == CHAR_NL) begin
        if (line_idx == 0 && !(magic_good && magic_n == 2)) bad = 1;
        if (line_idx < 3) line_idx++;
      end else if (line_idx == 0) begin
        if (magic_n == 0 && b != CHAR_P) magic_good = 0;
        else if (magic_n == 1 && b != CHAR_6) magic_good = 0;
        else if (magic_n >= 2) magic_good = 0;
        if (magic_n < 3) magic_n++;
      end else if (line_idx == 1) begin
        if (b == CHAR_SP) begin
          on_height = 1;
        end else if (is_digit) begin
          if (on_height) hgt = dec_push(hgt, b - CHAR_0);
          else wid = dec_push(wid, b - CHAR_0);
        end
      end else if (line_idx == 2) begin
        if (is_digit) dep = dec_push(dep, b - CHAR_0);
      end
      hdr_cnt++;
      if (bad) begin
        in_error = 1;
        has_res = 1;
        res = make_res(KIND_REPORT, last, ST_BAD_MAGIC);
        if (last) clear_parser();
      end else if (hdr_cnt >= HEADER_BYTES) begin
        has_res = 1;
        res = make_res(KIND_HEADER, last, ST_OK);
        if (last) clear_parser();
      end else if (last) begin
        has_res = 1;
        res = make_res(KIND_REPORT, 1'b1, ST_TRUNCATED);
        clear_parser();
      end
      return;
    end
    if (phase == 0) begin
      hold_r = b;
      phase = 1;
    end else if (phase == 1) begin
      hold_g = b;
      phase = 2;
    end else begin
      has_res = 1;
      res = make_res(KIND_PIXEL, last, ST_OK, col, row, hold_r, hold_g, b);
      phase = 0;
      if (col + 1 >= wid) begin
        col = 0;
        row = (row + 1) & 32'hFFFF;
      end else begin
        col++;
      end
      if (last) clear_parser();
      return;
    end
    if (last) begin
      has_res = 1;
      res = make_res(KIND_REPORT, 1'b1, ST_BAD_LENGTH);
      clear_parser();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // The driver owns both handshake inputs; it moves at the falling edge.
  always @(negedge clk_i) begin
    byte_req_t cur;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_fire) begin
        if (byte_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= cur.data;
          s_axis_tlast <= cur.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !hold_long && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // The monitor predicts each accepted request and checks each accepted result.
  always @(posedge clk_i) begin
    pixmap_res_t want;
    bit got;
    if (!rst_ni) begin
      in_fire = 1'b0;
    end else begin
      in_fire = s_axis_tvalid && s_axis_tready;
      if (in_fire) begin
        predict_byte(s_axis_tdata, s_axis_tlast, got, want);
        if (got) pixel_exp_q.insert(pixel_exp_q.size(), want);
        bytes_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_exp_q.size() == 0) begin
          $error("unexpected result: kind %0d", m_axis_tuser);
          err_cnt++;
        end else begin
          want = pixel_exp_q.pop_front();
          check_field("kind", want.kind, m_axis_tuser);
          check_field("final_res", want.fin, m_axis_tlast);
          check_field("status", want.status, m_axis_tdata[1:0]);
          check_field("pixel_x", want.x, m_axis_tdata[17:2]);
          check_field("pixel_y", want.y, m_axis_tdata[33:18]);
          check_field("red", want.r, m_axis_tdata[41:34]);
          check_field("green", want.g, m_axis_tdata[49:42]);
          check_field("blue", want.b, m_axis_tdata[57:50]);
          check_field("image_width", want.w, m_axis_tdata[73:58]);
          check_field("image_height", want.h, m_axis_tdata[89:74]);
          check_field("color_depth", want.d, m_axis_tdata[105:90]);
        end
      end
    end
  end

  task automatic add_text(inout file_bytes_t f, input string s);
    for (int i = 0; i < s.len(); i++) f.insert(f.size(), s[i]);
  endtask

  task automatic add_random(inout file_bytes_t f, input int n);
    for (int i = 0; i < n; i++) f.insert(f.size(), 8'($urandom_range(0, 255)));
  endtask

  task automatic queue_file(input file_bytes_t f);
    byte_req_t req;
    for (int i = 0; i < f.size(); i++) begin
      req.data = f[i];
      req.last = (i == f.size() - 1);
      byte_q.insert(byte_q.size(), req);
      bytes_queued++;
    end
  endtask

  function automatic string header_text();
    int unsigned w;
    int unsigned h;
    int unsigned d;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99999) : $urandom_range(0, 5);
    h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99999) : $urandom_range(0, 9);
    d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70000) : 255;
    return $sformatf("P6\n%0d %0d\n%0d\n", w, h, d);
  endfunction

  task automatic queue_random_file();
    file_bytes_t f;
    string hdr;
    int sel;
    int cut;
    sel = $urandom_range(0, 9);
    hdr = header_text();
    add_text(f, hdr);
    if (f.size() < HEADER_BYTES) add_random(f, HEADER_BYTES - f.size());
    if (sel <= 6) begin
      if ($urandom_range(0, 7) == 0) add_random(f, 3 * $urandom_range(20, 40));
      else add_random(f, 3 * $urandom_range(0, 10));
      if (sel == 6) add_random(f, $urandom_range(1, 2));
    end else if (sel == 7) begin
      f.delete();
      add_random(f, $urandom_range(1, 40));
    end else if (sel == 8) begin
      cut = $urandom_range(1, HEADER_BYTES - 1);
      while (f.size() > cut) void'(f.pop_back());
    end else begin
      f.delete();
      case ($urandom_range(0, 5))
        0: add_text(f, "P5");
        1: add_text(f, "p6");
        2: add_text(f, "P66");
        3: add_text(f, "6P");
        4: add_text(f, "P");
        default: ;
      endcase
      add_text(f, "\n");
      add_random(f, $urandom_range(0, 30));
    end
    queue_file(f);
  endtask

  task automatic queue_directed();
    file_bytes_t f;
    add_text(f, "P6\n2 2\n255\n#abc\n");
    f = {f, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    f = {f, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA};
    queue_file(f);
    f.delete();
    add_text(f, "P6\n99999 70000\n9");
    f = {f, 8'h80};
    queue_file(f);
    f.delete();
    add_text(f, "P6\n0 3\n65535\n#a\n");
    f = {f, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h7F};
    queue_file(f);
    f.delete();
    add_text(f, "P6\n1a 2 3\nx7y\n#\n");
    f = {f, 8'hFE, 8'hFD, 8'hFB};
    queue_file(f);
    f.delete();
    add_text(f, "P7\n1 1\njunk");
    queue_file(f);
    f.delete();
    add_text(f, "P66\n1 1\n");
    queue_file(f);
    f.delete();
    add_text(f, "P6\n4 ");
    queue_file(f);
    f.delete();
    add_text(f, "P\n");
    queue_file(f);
    f.delete();
    add_text(f, "P6P6P6P6P6P6P6P6");
    f = {f, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'h00};
    queue_file(f);
    f.delete();
    add_text(f, "P6\n1 1\n1\n######\n");
    queue_file(f);
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || s_axis_tvalid || pixel_exp_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clear_parser();
    queue_directed();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      @(posedge clk_i);
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      while (bytes_queued < 400 * (p + 1)) queue_random_file();
      wait_drained();
    end
    repeat (20) @(posedge clk_i);
    if (pixel_exp_q.size() != 0) begin
      $error("%0d expected results never arrived", pixel_exp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Long receiver hold-off so the parser fills up and stops taking requests.
  initial begin
    wait (bytes_taken >= 250);
    @(negedge clk_i);
    hold_long <= 1'b1;
    repeat (300) @(negedge clk_i);
    hold_long <= 1'b0;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
